[sv/necir_pkg.sv]
package necir_pkg;

   localparam int unsigned DurW   = 15;
   localparam int unsigned ByteW  = 8;
   localparam int unsigned RepW   = 4;
   localparam int unsigned WordW  = 32;
   localparam int unsigned BitCntW = $clog2(WordW);
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned MaxRepeats = 15;

   localparam logic [DurW-1:0] LeaderMarkRst  = 15'd9000;
   localparam logic [DurW-1:0] LeaderSpaceRst = 15'd4500;
   localparam logic [DurW-1:0] BitMarkRst     = 15'd560;
   localparam logic [DurW-1:0] ZeroSpaceRst   = 15'd560;
   localparam logic [DurW-1:0] OneSpaceRst    = 15'd1690;
   localparam logic [DurW-1:0] RepeatSpaceRst = 15'd2250;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LEADER_MARK  = 3'd0,
      CSR_LEADER_SPACE = 3'd1,
      CSR_BIT_MARK     = 3'd2,
      CSR_ZERO_SPACE   = 3'd3,
      CSR_ONE_SPACE    = 3'd4,
      CSR_REPEAT_SPACE = 3'd5
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_LEADER     = 6'b000010,
      ST_DATA       = 6'b000100,
      ST_END        = 6'b001000,
      ST_REP_LEADER = 6'b010000,
      ST_REP_END    = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      SYM_LEADER     = 3'd0,
      SYM_DATA       = 3'd1,
      SYM_END        = 3'd2,
      SYM_REP_LEADER = 3'd3,
      SYM_REP_END    = 3'd4
   } sym_type;

   typedef struct packed {
      logic    start;
      logic    emit;
      sym_type sym;
   } dp_cmd_type;

   typedef struct packed {
      logic bit_last;
      logic reps_zero;
   } dp_status_type;

endpackage

[sv/necir_dp.sv]
module necir_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  necir_pkg::dp_cmd_type                 cmd,
   output necir_pkg::dp_status_type              status,
   input  logic [necir_pkg::ByteW-1:0]           req_address,
   input  logic [necir_pkg::ByteW-1:0]           req_command,
   input  logic [necir_pkg::RepW-1:0]            req_repeats,
   input  logic                                  csr_we,
   input  logic [necir_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [necir_pkg::DurW-1:0]            csr_wdata,
   output logic [necir_pkg::DurW-1:0]            rsp_mark_us,
   output logic [necir_pkg::DurW-1:0]            rsp_space_us,
   output logic                                  rsp_frame_end,
   output logic                                  rsp_last
);

   logic [necir_pkg::DurW-1:0] leader_mark_ff, leader_space_ff, bit_mark_ff;
   logic [necir_pkg::DurW-1:0] zero_space_ff, one_space_ff, repeat_space_ff;

   logic [necir_pkg::WordW-1:0]   frame_word_ff, frame_word_in;
   logic [necir_pkg::BitCntW-1:0] bit_cnt_ff, bit_cnt_in;
   logic [necir_pkg::RepW-1:0]    reps_ff, reps_in;

   logic [necir_pkg::DurW-1:0] mark_ff, mark_in, space_ff, space_in;
   logic                       frame_end_ff, frame_end_in, last_ff, last_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         leader_mark_ff  <= necir_pkg::LeaderMarkRst;
         leader_space_ff <= necir_pkg::LeaderSpaceRst;
         bit_mark_ff     <= necir_pkg::BitMarkRst;
         zero_space_ff   <= necir_pkg::ZeroSpaceRst;
         one_space_ff    <= necir_pkg::OneSpaceRst;
         repeat_space_ff <= necir_pkg::RepeatSpaceRst;
      end else if (csr_we) begin
         case (necir_pkg::csr_index_type'(csr_index))
            necir_pkg::CSR_LEADER_MARK:  leader_mark_ff  <= csr_wdata;
            necir_pkg::CSR_LEADER_SPACE: leader_space_ff <= csr_wdata;
            necir_pkg::CSR_BIT_MARK:     bit_mark_ff     <= csr_wdata;
            necir_pkg::CSR_ZERO_SPACE:   zero_space_ff   <= csr_wdata;
            necir_pkg::CSR_ONE_SPACE:    one_space_ff    <= csr_wdata;
            necir_pkg::CSR_REPEAT_SPACE: repeat_space_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame word, bit counter, repeat counter
   always_comb begin
      frame_word_in = frame_word_ff;
      bit_cnt_in    = bit_cnt_ff;
      reps_in       = reps_ff;
      if (cmd.start) begin
         frame_word_in = {~req_command, req_command, ~req_address, req_address};
         bit_cnt_in    = '0;
         reps_in       = req_repeats;
      end else if (cmd.emit) begin
         if (cmd.sym == necir_pkg::SYM_DATA) begin
            frame_word_in = frame_word_ff >> 1;
            bit_cnt_in    = bit_cnt_ff + 1'b1;
         end
         if (cmd.sym == necir_pkg::SYM_REP_LEADER) begin
            reps_in = reps_ff - 1'b1;
         end
      end
   end

   // symbol select
   always_comb begin
      mark_in      = mark_ff;
      space_in     = space_ff;
      frame_end_in = frame_end_ff;
      last_in      = last_ff;
      if (cmd.emit) begin
         case (cmd.sym)
            necir_pkg::SYM_LEADER: begin
               mark_in      = leader_mark_ff;
               space_in     = leader_space_ff;
               frame_end_in = 1'b0;
               last_in      = 1'b0;
            end
            necir_pkg::SYM_DATA: begin
               mark_in      = bit_mark_ff;
               space_in     = frame_word_ff[0] ? one_space_ff : zero_space_ff;
               frame_end_in = 1'b0;
               last_in      = 1'b0;
            end
            necir_pkg::SYM_REP_LEADER: begin
               mark_in      = leader_mark_ff;
               space_in     = repeat_space_ff;
               frame_end_in = 1'b0;
               last_in      = 1'b0;
            end
            default: begin
               // end pulse of a full or a repeat frame
               mark_in      = bit_mark_ff;
               space_in     = '0;
               frame_end_in = 1'b1;
               last_in      = (reps_ff == '0);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      frame_word_ff <= frame_word_in;
      bit_cnt_ff    <= bit_cnt_in;
      reps_ff       <= reps_in;
      mark_ff       <= mark_in;
      space_ff      <= space_in;
      frame_end_ff  <= frame_end_in;
      last_ff       <= last_in;
   end

   assign status.bit_last  = (bit_cnt_ff == {necir_pkg::BitCntW{1'b1}});
   assign status.reps_zero = (reps_ff == '0);

   assign rsp_mark_us   = mark_ff;
   assign rsp_space_us  = space_ff;
   assign rsp_frame_end = frame_end_ff;
   assign rsp_last      = last_ff;

endmodule

[sv/necir_ctrl.sv]
module necir_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output necir_pkg::dp_cmd_type    cmd,
   input  necir_pkg::dp_status_type status
);

   necir_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free;

   assign req_ready = (state_ff == necir_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.start = req_valid && req_ready;
      cmd.emit  = slot_free && (state_ff != necir_pkg::ST_IDLE);
      case (state_ff)
         necir_pkg::ST_DATA:       cmd.sym = necir_pkg::SYM_DATA;
         necir_pkg::ST_END:        cmd.sym = necir_pkg::SYM_END;
         necir_pkg::ST_REP_LEADER: cmd.sym = necir_pkg::SYM_REP_LEADER;
         necir_pkg::ST_REP_END:    cmd.sym = necir_pkg::SYM_REP_END;
         default:                  cmd.sym = necir_pkg::SYM_LEADER;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         necir_pkg::ST_IDLE: begin
            if (cmd.start) state_in = necir_pkg::ST_LEADER;
         end
         necir_pkg::ST_LEADER: begin
            if (cmd.emit) state_in = necir_pkg::ST_DATA;
         end
         necir_pkg::ST_DATA: begin
            if (cmd.emit && status.bit_last) state_in = necir_pkg::ST_END;
         end
         necir_pkg::ST_END, necir_pkg::ST_REP_END: begin
            if (cmd.emit) begin
               state_in = status.reps_zero ? necir_pkg::ST_IDLE : necir_pkg::ST_REP_LEADER;
            end
         end
         necir_pkg::ST_REP_LEADER: begin
            if (cmd.emit) state_in = necir_pkg::ST_REP_END;
         end
         default: state_in = necir_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= necir_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_start_to_leader: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == necir_pkg::ST_LEADER)
      else $error("accepted request did not enter leader");

   a_data_to_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && state_ff == necir_pkg::ST_DATA && status.bit_last)
      |=> state_ff == necir_pkg::ST_END)
      else $error("frame did not close after the 32nd bit");

   a_rep_pair: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && state_ff == necir_pkg::ST_REP_LEADER)
      |=> state_ff == necir_pkg::ST_REP_END)
      else $error("repeat leader not followed by its end pulse");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted symbol not presented");
`endif

endmodule

[sv/nec_ir_frame_symbol_generator.sv]
// NEC infrared transmit encoder: one request becomes 34 + 2 * repeats symbols.
// The first symbol is registered only after the sequencer has entered leader.
// Throughput: one symbol per cycle while rsp_ready is high; the next request
// is taken only once the last symbol of the current one is loaded.
// Reset (synchronous) idles the sequencer and restores default durations.
module nec_ir_frame_symbol_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [necir_pkg::ByteW-1:0]   req_address,
   input  logic [necir_pkg::ByteW-1:0]   req_command,
   input  logic [necir_pkg::RepW-1:0]    req_repeats,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [necir_pkg::DurW-1:0]    rsp_mark_us,
   output logic [necir_pkg::DurW-1:0]    rsp_space_us,
   output logic                          rsp_frame_end,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [necir_pkg::CsrIdxW-1:0] csr_index,
   input  logic [necir_pkg::DurW-1:0]    csr_wdata
);

   // Command and status between the sequencer and the symbol datapath.
   necir_pkg::dp_cmd_type    cmd;
   necir_pkg::dp_status_type status;

   // Sequencer: leader, 32 data bits LSB first, end pulse, then a
   // repeat leader / end pulse pair per repeat. Advance only when the
   // output register is empty or being drained.
   necir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: duration registers, frame word shifter, bit and repeat
   // counters, and the registered symbol payload.
   necir_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_address      (req_address),
      .req_command      (req_command),
      .req_repeats      (req_repeats),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_mark_us      (rsp_mark_us),
      .rsp_space_us     (rsp_space_us),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_last         (rsp_last)
   );

endmodule
